[hw/rtl/pti_pkg.sv]
// ----------------------------------------------------------------------------
// pti_pkg: shared constants and types for the point-in-tetrahedron test unit
// Field and register widths, vertex register indexes and the sign summary of
// the tetrahedron's own orientation determinant.
// ----------------------------------------------------------------------------
package pti_pkg;

	// Default coordinate width and its legal range
	localparam int COORD_BITS_DEF = 21;
	localparam int COORD_BITS_MIN = 8;
	localparam int COORD_BITS_MAX = 21;

	// Port widths fixed by the interface
	localparam int FIELD_W = 21;
	localparam int REG_W   = 63;
	localparam int IDX_W   = 2;

	// Vertex register indexes
	localparam logic [IDX_W-1:0] VTX_A = 2'd0;
	localparam logic [IDX_W-1:0] VTX_B = 2'd1;
	localparam logic [IDX_W-1:0] VTX_C = 2'd2;
	localparam logic [IDX_W-1:0] VTX_D = 2'd3;

	// Cycles the derived-geometry pipeline needs after a register write
	localparam int CFG_SETTLE = 6;
	localparam int SETTLE_W   = $clog2(CFG_SETTLE + 1);

	// Sign of orient(a,b,c,d)
	typedef struct packed {
		logic neg;
		logic zero;
	} orient_t;

endpackage

[hw/rtl/pti_cfg_pipe.sv]
// ----------------------------------------------------------------------------
// pti_cfg_pipe: vertex registers and derived face normals
// Holds the four vertices, forms the four face normals and the sign of the
// tetrahedron's own determinant in a free-running pipeline, and reports busy
// until that pipeline has settled after reset or a register write.
// ----------------------------------------------------------------------------
module pti_cfg_pipe #(
	parameter int COORD_BITS = pti_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pti_pkg::IDX_W-1:0]       cfg_index,
	input  logic [pti_pkg::REG_W-1:0]       cfg_data,
	output logic signed [COORD_BITS-1:0]    vtx_c [3],
	output logic signed [COORD_BITS-1:0]    vtx_d [3],
	output logic signed [2*COORD_BITS+2:0]  nrm [4][3],
	output pti_pkg::orient_t                base,
	output logic                            busy
);

	localparam int C  = COORD_BITS;
	localparam int D  = C + 1;
	localparam int PW = 2 * D;
	localparam int NW = 2 * D + 1;
	localparam int TW = 3 * D + 1;
	localparam int SW = 3 * D + 3;

	logic [pti_pkg::REG_W-1:0]    vtx_q [4];
	logic [pti_pkg::SETTLE_W-1:0] cnt_q;

	logic signed [C-1:0]  crd [4][3];
	logic signed [D-1:0]  ad_s1 [3];
	logic signed [D-1:0]  bd_s1 [3];
	logic signed [D-1:0]  cd_s1 [3];
	logic signed [D-1:0]  ac_s1 [3];
	logic signed [D-1:0]  bc_s1 [3];
	logic signed [D-1:0]  opx [4][3];
	logic signed [D-1:0]  opy [4][3];
	logic signed [D-1:0]  ad_s2 [3];
	logic signed [D-1:0]  ad_s3 [3];
	logic signed [PW-1:0] prl_s2 [4][3];
	logic signed [PW-1:0] prr_s2 [4][3];
	logic signed [NW-1:0] nrm_s3 [4][3];
	logic signed [TW-1:0] trm_s4 [3];
	logic signed [SW-1:0] sum_s5;
	pti_pkg::orient_t     base_s6;

	// registers and settle counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				vtx_q[i] <= '0;
			end
			cnt_q <= pti_pkg::SETTLE_W'(pti_pkg::CFG_SETTLE);
		end else begin
			if (cfg_we) begin
				vtx_q[cfg_index] <= cfg_data;
				cnt_q <= pti_pkg::SETTLE_W'(pti_pkg::CFG_SETTLE);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// unpack x, y, z; bits at or above 3*C are unused
	always_comb begin
		for (int v = 0; v < 4; v++) begin
			for (int k = 0; k < 3; k++) begin
				crd[v][k] = vtx_q[v][k*C +: C];
			end
		end
	end

	// edge vectors
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			ad_s1[k] <= D'(crd[pti_pkg::VTX_A][k]) - D'(crd[pti_pkg::VTX_D][k]);
			bd_s1[k] <= D'(crd[pti_pkg::VTX_B][k]) - D'(crd[pti_pkg::VTX_D][k]);
			cd_s1[k] <= D'(crd[pti_pkg::VTX_C][k]) - D'(crd[pti_pkg::VTX_D][k]);
			ac_s1[k] <= D'(crd[pti_pkg::VTX_A][k]) - D'(crd[pti_pkg::VTX_C][k]);
			bc_s1[k] <= D'(crd[pti_pkg::VTX_B][k]) - D'(crd[pti_pkg::VTX_C][k]);
			ad_s2[k] <= ad_s1[k];
			ad_s3[k] <= ad_s2[k];
		end
	end

	// normals: (b-d)x(c-d), (c-d)x(a-d), (a-d)x(b-d), (a-c)x(b-c)
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			opx[0][k] = bd_s1[k];
			opy[0][k] = cd_s1[k];
			opx[1][k] = cd_s1[k];
			opy[1][k] = ad_s1[k];
			opx[2][k] = ad_s1[k];
			opy[2][k] = bd_s1[k];
			opx[3][k] = ac_s1[k];
			opy[3][k] = bc_s1[k];
		end
	end

	for (genvar j = 0; j < 4; j++) begin : g_nrm
		for (genvar k = 0; k < 3; k++) begin : g_cmp
			localparam int K1 = (k + 1) % 3;
			localparam int K2 = (k + 2) % 3;
			always_ff @(posedge clk) begin
				prl_s2[j][k] <= PW'(opx[j][K1]) * PW'(opy[j][K2]);
				prr_s2[j][k] <= PW'(opx[j][K2]) * PW'(opy[j][K1]);
				nrm_s3[j][k] <= NW'(prl_s2[j][k]) - NW'(prr_s2[j][k]);
			end
		end
	end

	// orient(a,b,c,d) = (a-d) . n0
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			trm_s4[k] <= TW'(ad_s3[k]) * TW'(nrm_s3[0][k]);
		end
		sum_s5       <= SW'(trm_s4[0]) + SW'(trm_s4[1]) + SW'(trm_s4[2]);
		base_s6.neg  <= sum_s5[SW-1];
		base_s6.zero <= (sum_s5 == '0);
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vtx_c[k] = crd[pti_pkg::VTX_C][k];
			vtx_d[k] = crd[pti_pkg::VTX_D][k];
		end
		for (int j = 0; j < 4; j++) begin
			for (int k = 0; k < 3; k++) begin
				nrm[j][k] = nrm_s3[j][k];
			end
		end
	end

	assign base = base_s6;
	assign busy = (cnt_q != '0);

endmodule

[hw/rtl/pti_det_pipe.sv]
// ----------------------------------------------------------------------------
// pti_det_pipe: per-point determinant pipeline
// Four stages: offsets of the point, products with the face normals, dot
// product sums, sign compare. All stages move together on en.
// ----------------------------------------------------------------------------
module pti_det_pipe #(
	parameter int COORD_BITS = pti_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            load,
	input  logic [pti_pkg::FIELD_W-1:0]     point_x,
	input  logic [pti_pkg::FIELD_W-1:0]     point_y,
	input  logic [pti_pkg::FIELD_W-1:0]     point_z,
	input  logic signed [COORD_BITS-1:0]    vtx_c [3],
	input  logic signed [COORD_BITS-1:0]    vtx_d [3],
	input  logic signed [2*COORD_BITS+2:0]  nrm [4][3],
	input  pti_pkg::orient_t                base,
	output logic                            vld,
	output logic                            inside_res,
	output logic                            degenerate
);

	localparam int C  = COORD_BITS;
	localparam int D  = C + 1;
	localparam int TW = 3 * D + 1;
	localparam int SW = 3 * D + 3;

	logic signed [C-1:0]  pc [3];
	logic signed [D-1:0]  u_s1 [3];
	logic signed [D-1:0]  v_s1 [3];
	logic signed [D-1:0]  opd [4][3];
	logic signed [TW-1:0] trm_s2 [4][3];
	logic signed [SW-1:0] sum_s3 [4];
	logic [3:0]           hit;
	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic                 inside_s4, degen_s4;

	// point read as two's complement at C bits
	assign pc[0] = point_x[C-1:0];
	assign pc[1] = point_y[C-1:0];
	assign pc[2] = point_z[C-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= load;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// first three faces use p-d, the last one p-c
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			for (int k = 0; k < 3; k++) begin
				opd[j][k] = (j == 3) ? v_s1[k] : u_s1[k];
			end
		end
	end

	// s4 flips sign: orient(a,b,c,p) = -(p-c) . n3
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			hit[j] = (sum_s3[j] != '0) &&
				(sum_s3[j][SW-1] == ((j == 3) ? !base.neg : base.neg));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				u_s1[k] <= D'(pc[k]) - D'(vtx_d[k]);
				v_s1[k] <= D'(pc[k]) - D'(vtx_c[k]);
			end
			for (int j = 0; j < 4; j++) begin
				for (int k = 0; k < 3; k++) begin
					trm_s2[j][k] <= TW'(opd[j][k]) * TW'(nrm[j][k]);
				end
				sum_s3[j] <= SW'(trm_s2[j][0]) + SW'(trm_s2[j][1]) + SW'(trm_s2[j][2]);
			end
			inside_s4 <= !base.zero && (&hit);
			degen_s4  <= base.zero;
		end
	end

	assign vld        = vld_s4;
	assign inside_res = inside_s4;
	assign degenerate = degen_s4;

endmodule

[hw/rtl/point_in_tetrahedron_test_unit.sv]
// ----------------------------------------------------------------------------
// point_in_tetrahedron_test_unit: strict point-in-tetrahedron test
// Exact integer orientation tests of a query point against four configured
// vertices; reports inside and a zero-volume flag for each point.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload                         Transfer when
//  -------  -------------------  ------------------------------  -------------------
//  input    in_valid / in_stall  point_x, point_y, point_z       in_valid & !in_stall
//  output   out_valid/out_stall  inside_res, degenerate          out_valid & !out_stall
//  config   cfg_we               cfg_index, cfg_data             cfg_we
//
//  One point per cycle, while in_stall is low, through four point stages; the
//  result is registered in the fourth. The four face normals and the
//  tetrahedron's own sign come from a six-stage geometry pipeline that runs off
//  the vertex registers; the input is stalled after reset, and during and after
//  every register write, while it settles. An output stall with out_valid high
//  freezes all four point stages together; nothing is dropped.
//  Reset clears the vertices to zero and all valid bits.
//
// Method: each substituted determinant is a dot product of the point offset
// with a face normal, det[p-d; b-d; c-d] = (p-d).((b-d)x(c-d)) and so on; the
// fourth uses orient(a,b,c,p) = -(p-c).((a-c)x(b-c)). All sums are exact.
// ----------------------------------------------------------------------------
module point_in_tetrahedron_test_unit #(
	parameter int COORD_BITS = pti_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// config port
	input  logic                        cfg_we,
	input  logic [pti_pkg::IDX_W-1:0]   cfg_index,
	input  logic [pti_pkg::REG_W-1:0]   cfg_data,
	// point input
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [pti_pkg::FIELD_W-1:0] point_x,
	input  logic [pti_pkg::FIELD_W-1:0] point_y,
	input  logic [pti_pkg::FIELD_W-1:0] point_z,
	// result output
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        inside_res,
	output logic                        degenerate
);

	logic signed [COORD_BITS-1:0]   vtx_c [3];
	logic signed [COORD_BITS-1:0]   vtx_d [3];
	logic signed [2*COORD_BITS+2:0] nrm [4][3];
	pti_pkg::orient_t               base;
	logic                           busy;
	logic                           en;
	logic                           load;

	// whole point pipeline advances unless the result register is held
	assign en       = !(out_valid && out_stall);
	// hold input while the output is held, geometry settles or a write is in progress
	assign in_stall = !en || busy || cfg_we;
	assign load     = in_valid && !in_stall;

	pti_cfg_pipe #(
		.COORD_BITS(COORD_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.vtx_c    (vtx_c),
		.vtx_d    (vtx_d),
		.nrm      (nrm),
		.base     (base),
		.busy     (busy)
	);

	pti_det_pipe #(
		.COORD_BITS(COORD_BITS)
	) u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.load      (load),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.vtx_c     (vtx_c),
		.vtx_d     (vtx_d),
		.nrm       (nrm),
		.base      (base),
		.vld       (out_valid),
		.inside_res(inside_res),
		.degenerate(degenerate)
	);

endmodule

[dv/tb_point_in_tetrahedron_test_unit.sv]
// ----------------------------------------------------------------------------
// tb_point_in_tetrahedron_test_unit: self-checking bench for the point test
// A short directed table (reset state, unit and extreme tetrahedra, boundary
// points, flat tetrahedra) is followed by randomized phases. Each phase loads a
// new tetrahedron and streams points, most of them weighted blends of the
// vertices so that inside, boundary and near-boundary cases come up often.
// Every result is compared with a hand-written verdict or an exact integer predictor.
// ----------------------------------------------------------------------------
module tb_point_in_tetrahedron_test_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB           = pti_pkg::COORD_BITS_DEF;
	localparam int MINC         = -(2 ** (CB - 1));
	localparam int MAXC         = 2 ** (CB - 1) - 1;
	localparam int PHASES       = 20;
	localparam int PHASE_POINTS = 85;
	localparam int TAIL_CYCLES  = 20;
	// The run sends roughly 1725 points plus config writes and settling; this
	// cycle limit leaves a wide margin over the slowest legal run.
	localparam longint CYCLE_LIMIT = 400000;

	// Exact determinant arithmetic: 22-bit differences, 3x3 determinant fits
	// in well under 96 bits.
	typedef logic signed [95:0] det_t;

	typedef struct {
		det_t x;
		det_t y;
		det_t z;
	} coord3_t;

	typedef struct packed {
		logic inner;
		logic degen;
	} verdict_t;

	typedef enum logic {ROW_CFG, ROW_PT} row_kind_t;

	// One line of the directed table: either a register write or a point,
	// optionally with a hand-written expected verdict.
	typedef struct packed {
		row_kind_t                   kind;
		logic [pti_pkg::IDX_W-1:0]   idx;
		logic [pti_pkg::REG_W-1:0]   data;
		logic [pti_pkg::FIELD_W-1:0] px;
		logic [pti_pkg::FIELD_W-1:0] py;
		logic [pti_pkg::FIELD_W-1:0] pz;
		logic                        typed;
		verdict_t                    want;
	} plan_row_t;

	// DUT signals, all inputs known from time zero
	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [pti_pkg::IDX_W-1:0]   cfg_index = '0;
	logic [pti_pkg::REG_W-1:0]   cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [pti_pkg::FIELD_W-1:0] point_x = '0;
	logic [pti_pkg::FIELD_W-1:0] point_y = '0;
	logic [pti_pkg::FIELD_W-1:0] point_z = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic                        inside_res;
	logic                        degenerate;

	// Bench copy of the vertex registers (reset value zero)
	logic [pti_pkg::REG_W-1:0] vertex_reg [4] = '{default: '0};

	verdict_t verdicts_due[$];

	int     send_pct = 0;
	int     stall_pct = 0;
	int     errors = 0;
	int     points_sent = 0;
	int     results_checked = 0;
	int     inside_seen = 0;
	int     degen_seen = 0;
	longint cycle_count = 0;

	point_in_tetrahedron_test_unit #(
		.COORD_BITS(CB)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.inside_res(inside_res),
		.degenerate(degenerate)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Coordinate number 'slot' of a packed word, sign-extended from CB bits.
	// Bits above the used coordinates never reach the result.
	function automatic det_t sext_coord(logic [pti_pkg::REG_W-1:0] r, int slot);
		logic [pti_pkg::REG_W-1:0] v;
		det_t w;
		int i;
		v = r >> (slot * CB);
		for (i = 0; i < 96; i++)
			w[i] = (i < CB) ? v[i] : v[CB-1];
		return w;
	endfunction

	function automatic coord3_t unpack_vertex(logic [pti_pkg::REG_W-1:0] r);
		coord3_t c;
		c.x = sext_coord(r, 0);
		c.y = sext_coord(r, 1);
		c.z = sext_coord(r, 2);
		return c;
	endfunction

	// Sign of det[a-d; b-d; c-d], exact
	function automatic int orient_sign(coord3_t a, coord3_t b, coord3_t c, coord3_t d);
		det_t adx, ady, adz, bdx, bdy, bdz, cdx, cdy, cdz;
		det_t m1, m2, m3, s;
		adx = a.x - d.x; ady = a.y - d.y; adz = a.z - d.z;
		bdx = b.x - d.x; bdy = b.y - d.y; bdz = b.z - d.z;
		cdx = c.x - d.x; cdy = c.y - d.y; cdz = c.z - d.z;
		m1 = bdx * cdy - cdx * bdy;
		m2 = cdx * ady - adx * cdy;
		m3 = adx * bdy - bdx * ady;
		s = adz * m1 + bdz * m2 + cdz * m3;
		if (s < 0)
			return -1;
		return (s != 0) ? 1 : 0;
	endfunction

	// Strictly-inside test of a point against the current vertex registers
	function automatic verdict_t classify_point(logic [pti_pkg::FIELD_W-1:0] x,
			logic [pti_pkg::FIELD_W-1:0] y, logic [pti_pkg::FIELD_W-1:0] z);
		coord3_t a, b, c, d, p;
		int s0, s1, s2, s3, s4;
		verdict_t v;
		a = unpack_vertex(vertex_reg[pti_pkg::VTX_A]);
		b = unpack_vertex(vertex_reg[pti_pkg::VTX_B]);
		c = unpack_vertex(vertex_reg[pti_pkg::VTX_C]);
		d = unpack_vertex(vertex_reg[pti_pkg::VTX_D]);
		// narrow widths: only the low CB bits of each field count
		p.x = sext_coord(pti_pkg::REG_W'(x), 0);
		p.y = sext_coord(pti_pkg::REG_W'(y), 0);
		p.z = sext_coord(pti_pkg::REG_W'(z), 0);
		s0 = orient_sign(a, b, c, d);
		s1 = orient_sign(p, b, c, d);
		s2 = orient_sign(a, p, c, d);
		s3 = orient_sign(a, b, p, d);
		s4 = orient_sign(a, b, c, p);
		v.degen = (s0 == 0);
		v.inner = (s0 != 0) && (s1 == s0) && (s2 == s0) && (s3 == s0) && (s4 == s0);
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [pti_pkg::REG_W-1:0] pack_vertex(int x, int y, int z);
		logic [pti_pkg::REG_W-1:0] r;
		r = '0;
		r[0 +: CB] = x[CB-1:0];
		r[CB +: CB] = y[CB-1:0];
		r[2*CB +: CB] = z[CB-1:0];
		return r;
	endfunction

	function automatic plan_row_t cfg_row(logic [pti_pkg::IDX_W-1:0] idx,
			logic [pti_pkg::REG_W-1:0] data);
		plan_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	// Point row with a hand-written verdict
	function automatic plan_row_t pt_exp(int x, int y, int z, logic ins, logic deg);
		plan_row_t row;
		row = '0;
		row.kind = ROW_PT;
		row.px = x[pti_pkg::FIELD_W-1:0];
		row.py = y[pti_pkg::FIELD_W-1:0];
		row.pz = z[pti_pkg::FIELD_W-1:0];
		row.typed = 1'b1;
		row.want = '{inner: ins, degen: deg};
		return row;
	endfunction

	// Point row left to the predictor
	function automatic plan_row_t pt_chk(int x, int y, int z);
		plan_row_t row;
		row = pt_exp(x, y, z, 1'b0, 1'b0);
		row.typed = 1'b0;
		return row;
	endfunction

	function automatic int pick_extreme();
		case ($urandom_range(0, 4))
			0: return MINC;
			1: return MAXC;
			2: return 0;
			3: return MINC + 1;
			default: return MAXC - 1;
		endcase
	endfunction

	function automatic int rand_coord(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Sender stops and waits until every pending result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(negedge clk);
	endtask

	// Register write, only ever done with the pipeline empty
	task automatic write_vertex(logic [pti_pkg::IDX_W-1:0] idx,
			logic [pti_pkg::REG_W-1:0] data);
		wait_drained();
		cfg_index <= idx;
		cfg_data <= data;
		cfg_we <= 1'b1;
		vertex_reg[idx] = data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Drive one point from a falling edge, hold it until the transfer, then
	// return at the next falling edge with valid still high.
	task automatic send_point(logic [pti_pkg::FIELD_W-1:0] x,
			logic [pti_pkg::FIELD_W-1:0] y, logic [pti_pkg::FIELD_W-1:0] z,
			logic typed, verdict_t want);
		while (send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		verdicts_due.push_back(typed ? want : classify_point(x, y, z));
		points_sent++;
		@(negedge clk);
	endtask

	// Random point: mostly weighted blends of the vertices (inside, on faces,
	// edges, vertices), some pushed outside, the rest raw noise or extremes.
	task automatic pick_point(output logic [pti_pkg::FIELD_W-1:0] px,
			output logic [pti_pkg::FIELD_W-1:0] py,
			output logic [pti_pkg::FIELD_W-1:0] pz);
		int mode, rot, i, j;
		int w[4];
		int u[4];
		int wt;
		longint nx, ny, nz;
		coord3_t v;
		mode = $urandom_range(0, 9);
		if (mode < 2) begin
			px = pti_pkg::FIELD_W'($urandom);
			py = pti_pkg::FIELD_W'($urandom);
			pz = pti_pkg::FIELD_W'($urandom);
		end else if (mode == 2) begin
			px = pti_pkg::FIELD_W'(pick_extreme());
			py = pti_pkg::FIELD_W'(pick_extreme());
			pz = pti_pkg::FIELD_W'(pick_extreme());
		end else begin
			// power-of-two total weight; small totals land exactly on
			// vertices, edge midpoints and face points
			wt = 1 << $urandom_range(0, 6);
			u[0] = $urandom_range(0, wt);
			u[1] = $urandom_range(0, wt - u[0]);
			u[2] = $urandom_range(0, wt - u[0] - u[1]);
			u[3] = wt - u[0] - u[1] - u[2];
			rot = $urandom_range(0, 3);
			for (i = 0; i < 4; i++)
				w[(i + rot) % 4] = u[i];
			if ($urandom_range(0, 3) == 0) begin
				j = $urandom_range(0, 3);
				w[j] = w[j] - int'($urandom_range(1, wt));
			end
			nx = 0;
			ny = 0;
			nz = 0;
			for (i = 0; i < 4; i++) begin
				v = unpack_vertex(vertex_reg[i]);
				nx += w[i] * longint'(v.x);
				ny += w[i] * longint'(v.y);
				nz += w[i] * longint'(v.z);
			end
			px = pti_pkg::FIELD_W'(nx / wt);
			py = pti_pkg::FIELD_W'(ny / wt);
			pz = pti_pkg::FIELD_W'(nz / wt);
		end
	endtask

	// New tetrahedron for a random phase.
	// Styles: full random words, tiny, extremes, flat, moderate.
	task automatic load_tetrahedron(int style);
		logic [pti_pkg::REG_W-1:0] vr[4];
		int q[4][3];
		int i, j, span;
		span = (style == 1) ? 12 : (style == 4) ? (MAXC / 1024 + 1) : (MAXC / 4);
		for (i = 0; i < 4; i++)
			for (j = 0; j < 3; j++)
				q[i][j] = (style == 2) ? pick_extreme() : rand_coord(span);
		if (style == 3) begin
			// flat: each coordinate of d repeats a's or is b + c - a; d lies in the plane of a, b, c when all pick alike
			for (j = 0; j < 3; j++)
				q[3][j] = ($urandom_range(0, 2) == 0) ? q[0][j] : q[1][j] + q[2][j] - q[0][j];
		end
		for (i = 0; i < 4; i++)
			vr[i] = (style == 0) ? pti_pkg::REG_W'({$urandom, $urandom}) :
				pack_vertex(q[i][0], q[i][1], q[i][2]);
		write_vertex(pti_pkg::VTX_A, vr[0]);
		write_vertex(pti_pkg::VTX_B, vr[1]);
		write_vertex(pti_pkg::VTX_C, vr[2]);
		write_vertex(pti_pkg::VTX_D, vr[3]);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall, driven on the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk)
		out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);

	// Result checker and run watchdog
	always @(posedge clk) begin
		verdict_t exp_v;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still pending",
				$time, cycle_count, verdicts_due.size());
			$display("== FAIL ==");
			$finish;
		end else if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				errors++;
				$display("%0t: result transfer with nothing pending (inside_res=%0b degenerate=%0b)",
					$time, inside_res, degenerate);
			end else begin
				exp_v = verdicts_due.pop_front();
				results_checked++;
				if (inside_res !== exp_v.inner) begin
					errors++;
					$display("%0t: inside_res expected %0b actual %0b",
						$time, exp_v.inner, inside_res);
				end
				if (degenerate !== exp_v.degen) begin
					errors++;
					$display("%0t: degenerate expected %0b actual %0b",
						$time, exp_v.degen, degenerate);
				end
				inside_seen += exp_v.inner;
				degen_seen += exp_v.degen;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		plan_row_t plan[$];
		logic [pti_pkg::FIELD_W-1:0] rx, ry, rz;
		int phase, n;

		plan = '{
			// all vertices zero after reset: flat, nothing inside
			pt_exp(0, 0, 0, 1'b0, 1'b1),
			pt_exp(MAXC, MAXC, MAXC, 1'b0, 1'b1),
			pt_exp(MINC, MINC, MINC, 1'b0, 1'b1),
			// corner tetrahedron along the axes, edge 64
			cfg_row(pti_pkg::VTX_A, pack_vertex(0, 0, 0)),
			cfg_row(pti_pkg::VTX_B, pack_vertex(64, 0, 0)),
			cfg_row(pti_pkg::VTX_C, pack_vertex(0, 64, 0)),
			cfg_row(pti_pkg::VTX_D, pack_vertex(0, 0, 64)),
			pt_exp(8, 8, 8, 1'b1, 1'b0),
			pt_exp(0, 0, 0, 1'b0, 1'b0),          // on a vertex
			pt_exp(32, 0, 0, 1'b0, 1'b0),         // on an edge
			pt_exp(10, 10, 0, 1'b0, 1'b0),        // on a coordinate face
			pt_exp(21, 21, 22, 1'b0, 1'b0),       // on the slanted face
			pt_exp(-1, 8, 8, 1'b0, 1'b0),         // just outside
			pt_exp(MAXC, MINC, MAXC, 1'b0, 1'b0),
			// same solid with b and c swapped: opposite orientation sign
			cfg_row(pti_pkg::VTX_B, pack_vertex(0, 64, 0)),
			cfg_row(pti_pkg::VTX_C, pack_vertex(64, 0, 0)),
			pt_exp(8, 8, 8, 1'b1, 1'b0),
			pt_exp(16, 16, 31, 1'b1, 1'b0),       // one step inside the slanted face
			// vertices at the coordinate extremes: widest products
			cfg_row(pti_pkg::VTX_A, pack_vertex(MINC, MINC, MINC)),
			cfg_row(pti_pkg::VTX_B, pack_vertex(MAXC, MINC, MINC)),
			cfg_row(pti_pkg::VTX_C, pack_vertex(MINC, MAXC, MINC)),
			cfg_row(pti_pkg::VTX_D, pack_vertex(MINC, MINC, MAXC)),
			pt_chk(MINC + 1, MINC + 1, MINC + 1),
			pt_chk(0, 0, 0),
			pt_exp(MINC, MINC, MINC, 1'b0, 1'b0),
			pt_chk(MAXC, MAXC, MAXC),
			pt_chk(-1, -1, -1),
			// four coplanar vertices
			cfg_row(pti_pkg::VTX_A, pack_vertex(0, 0, 0)),
			cfg_row(pti_pkg::VTX_B, pack_vertex(64, 0, 0)),
			cfg_row(pti_pkg::VTX_C, pack_vertex(0, 64, 0)),
			cfg_row(pti_pkg::VTX_D, pack_vertex(64, 64, 0)),
			pt_exp(8, 8, 0, 1'b0, 1'b1),
			pt_exp(8, 8, 8, 1'b0, 1'b1),
			// every register at its all-ones maximum: four equal vertices
			cfg_row(pti_pkg::VTX_A, '1),
			cfg_row(pti_pkg::VTX_B, '1),
			cfg_row(pti_pkg::VTX_C, '1),
			cfg_row(pti_pkg::VTX_D, '1),
			pt_exp(-1, -1, -1, 1'b0, 1'b1)
		};

		// reset once, released on a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, no idling on either side
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_vertex(plan[i].idx, plan[i].data);
			else
				send_point(plan[i].px, plan[i].py, plan[i].pz, plan[i].typed, plan[i].want);
		end

		// random phases: idling pattern cycles over four modes, tetrahedron
		// style over five, so every pairing shows up
		for (phase = 0; phase < PHASES; phase++) begin
			load_tetrahedron(phase % 5);
			case (phase % 4)
				0: begin send_pct = 0;  stall_pct = 0;  end
				1: begin send_pct = 75; stall_pct = 0;  end
				2: begin send_pct = 0;  stall_pct = 75; end
				default: begin send_pct = 23; stall_pct = 23; end
			endcase
			for (n = 0; n < PHASE_POINTS; n++) begin
				// mid-phase hold-off: sender waits for the pipe to empty
				if (n == PHASE_POINTS / 2 && phase % 4 == 2)
					wait_drained();
				pick_point(rx, ry, rz);
				send_point(rx, ry, rz, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d points over %0d tetrahedra, %0d results checked.",
			points_sent, PHASES + 5, results_checked);
		$display("Verdicts: %0d inside, %0d on a flat tetrahedron, %0d mismatches.",
			inside_seen, degen_seen, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[point_in_tetrahedron_test_unit.f]
hw/rtl/pti_pkg.sv
hw/rtl/pti_cfg_pipe.sv
hw/rtl/pti_det_pipe.sv
hw/rtl/point_in_tetrahedron_test_unit.sv
dv/tb_point_in_tetrahedron_test_unit.sv
